// ===== rtl/kmd_pkg.sv =====
`timescale 1ns / 1ps

package kmd_pkg;

  // Fixed field widths of the event channel
  localparam int ROW_IDX_W  = 4;
  localparam int COL_LVL_W  = 8;
  localparam int KEY_COL_W  = 3;
  localparam int MAX_COLS   = 8;
  localparam int CNT_W      = 4;

  // Matrix size and queue defaults
  localparam int ROWS_DEFAULT        = 5;
  localparam int COLS_DEFAULT        = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Configuration registers
  localparam int              CFG_IDX_W  = 1;
  localparam int              CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_ENABLED = 1'b1;
  localparam logic [CNT_W-1:0]     STABLE_COUNT_RESET = 4'd3;

  // One classified row sample waiting for event emission
  typedef struct packed {
    logic [ROW_IDX_W-1:0] row;
    logic [MAX_COLS-1:0]  mask;  // keys whose debounced state flipped
    logic [MAX_COLS-1:0]  bits;  // debounced row state after the update
  } evt_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/kmd_front.sv =====
`timescale 1ns / 1ps

module kmd_front import kmd_pkg::*; #(
  parameter int ROWS = ROWS_DEFAULT,
  parameter int COLS = COLS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ROW_IDX_W-1:0] in_row_index,
  input  logic [COL_LVL_W-1:0] in_col_levels,
  input  logic [CNT_W-1:0]     stable_count,
  input  logic                 events_enabled,
  input  fifo_stat_t           q_stat,
  output logic                 q_push,
  output evt_entry_t           q_wdata
);

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Per-row debounced state and per-key disagreement counters
  logic [COLS-1:0]             deb_r [ROWS];
  logic [COLS-1:0][CNT_W-1:0]  cnt_r [ROWS];

  logic                        accept;
  logic                        row_ok;
  logic [ROW_W-1:0]            ridx;
  logic [COLS-1:0]             deb_row_nxt;
  logic [COLS-1:0][CNT_W-1:0]  cnt_row_nxt;
  logic [COLS-1:0]             changed;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign row_ok   = ({1'b0, in_row_index} < (ROW_IDX_W + 1)'(ROWS));
  assign ridx     = in_row_index[ROW_W-1:0];

  // Classify each key of the sampled row
  always_comb begin
    logic [CNT_W-1:0] cnt_inc;
    logic             key_down;
    deb_row_nxt = deb_r[ridx];
    cnt_row_nxt = cnt_r[ridx];
    changed     = '0;
    for (int c = 0; c < COLS; c++) begin
      key_down = !in_col_levels[c];
      cnt_inc  = cnt_r[ridx][c] + CNT_W'(1);
      if (key_down == deb_r[ridx][c]) begin
        cnt_row_nxt[c] = '0;
      end else if (cnt_inc >= stable_count || cnt_inc == '0) begin
        deb_row_nxt[c] = key_down;
        changed[c]     = 1'b1;
        cnt_row_nxt[c] = '0;
      end else begin
        cnt_row_nxt[c] = cnt_inc;
      end
    end
  end

  // Write back the row state on every accepted in-range item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        deb_r[r] <= '0;
        cnt_r[r] <= '0;
      end
    end else if (accept && row_ok) begin
      deb_r[ridx] <= deb_row_nxt;
      cnt_r[ridx] <= cnt_row_nxt;
    end
  end

  // Hand rows with flips to the back end
  always_comb begin
    q_push                    = accept && row_ok && events_enabled && (|changed);
    q_wdata                   = '0;
    q_wdata.row               = in_row_index;
    q_wdata.mask[COLS-1:0]    = changed;
    q_wdata.bits[COLS-1:0]    = deb_row_nxt;
  end

endmodule

// ===== rtl/kmd_fifo.sv =====
`timescale 1ns / 1ps

module kmd_fifo import kmd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  evt_entry_t wdata,
  input  logic       pop,
  output evt_entry_t rdata,
  output fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  evt_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [FILL_W-1:0]  fill_r;

  assign stat.full  = (fill_r == FILL_W'(DEPTH));
  assign stat.empty = (fill_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - FILL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/kmd_back.sv =====
`timescale 1ns / 1ps

module kmd_back import kmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  evt_entry_t           q_rdata,
  input  fifo_stat_t           q_stat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_IDX_W-1:0] out_key_row,
  output logic [KEY_COL_W-1:0] out_key_col,
  output logic                 out_pressed,
  output logic                 out_last_event
);

  logic                  busy_r, busy_nxt;
  evt_entry_t            ent_r, ent_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ROW_IDX_W-1:0]  row_r;
  logic [KEY_COL_W-1:0]  col_r;
  logic                  pressed_r;
  logic                  last_r;

  logic                  can_load;
  logic                  emit;
  logic                  done;
  logic [KEY_COL_W-1:0]  sel;
  logic [MAX_COLS-1:0]   rest;

  // Pick the lowest pending column
  always_comb begin
    sel = '0;
    for (int c = MAX_COLS - 1; c >= 0; c--) begin
      if (ent_r.mask[c]) begin
        sel = KEY_COL_W'(c);
      end
    end
  end

  assign rest     = ent_r.mask & (ent_r.mask - MAX_COLS'(1));
  assign can_load = !out_valid_r || out_ready;
  assign emit     = busy_r && can_load;
  assign done     = emit && (rest == '0);
  assign q_pop    = !q_stat.empty && (!busy_r || done);

  // Advance through the pending columns of the current entry
  always_comb begin
    busy_nxt = busy_r;
    ent_nxt  = ent_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      ent_nxt  = q_rdata;
    end else if (emit) begin
      busy_nxt      = !done;
      ent_nxt.mask  = rest;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the entry and the output payload
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (emit) begin
      row_r     <= ent_r.row;
      col_r     <= sel;
      pressed_r <= ent_r.bits[sel];
      last_r    <= (rest == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_row    = row_r;
  assign out_key_col    = col_r;
  assign out_pressed    = pressed_r;
  assign out_last_event = last_r;

endmodule

// ===== rtl/key_matrix_debounce_events_top.sv =====
`timescale 1ns / 1ps

// Key matrix debouncer with change events. Each input item is one scanned
// row (row index, column levels, low = pressed); every key keeps a
// debounced bit and a 4-bit disagreement counter, and a key flips once it
// has disagreed on stable_count consecutive scans. The front end takes one
// item per clock whenever the event queue has room, updating the row state
// in the same cycle; rows that produced flips (with events enabled) enter
// the queue. The back end emits one event per clock while out_ready allows,
// in ascending column order, so a row with several flips occupies it for
// one event per flip and the sustained rate is set by that emitter; items
// that cause no event do not enter the queue. State is cleared at once
// by reset; there is no clearing pass. Write configuration only while idle.
module key_matrix_debounce_events_top import kmd_pkg::*; #(
  parameter int ROWS        = ROWS_DEFAULT,
  parameter int COLS        = COLS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ROW_IDX_W-1:0]  in_row_index,
  input  logic [COL_LVL_W-1:0]  in_col_levels,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROW_IDX_W-1:0]  out_key_row,
  output logic [KEY_COL_W-1:0]  out_key_col,
  output logic                  out_pressed,
  output logic                  out_last_event,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] stable_count_r;
  logic             events_enabled_r;

  logic             q_push;
  logic             q_pop;
  evt_entry_t       q_wdata;
  evt_entry_t       q_rdata;
  fifo_stat_t       q_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_count_r   <= STABLE_COUNT_RESET;
      events_enabled_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STABLE_COUNT:   stable_count_r   <= cfg_wdata[CNT_W-1:0];
        CFG_EVENTS_ENABLED: events_enabled_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  kmd_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_row_index  (in_row_index),
    .in_col_levels (in_col_levels),
    .stable_count  (stable_count_r),
    .events_enabled(events_enabled_r),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  kmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  kmd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rdata       (q_rdata),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_row   (out_key_row),
    .out_key_col   (out_key_col),
    .out_pressed   (out_pressed),
    .out_last_event(out_last_event)
  );

  // Queue is never written when full nor read when empty
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
    else $error("event queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
    else $error("event queue underflow");

  // Emitted events name a key inside the matrix
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_key_row} < (ROW_IDX_W + 1)'(ROWS)))
    else $error("event row outside matrix");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_key_col} < (KEY_COL_W + 1)'(COLS)))
    else $error("event column outside matrix");

endmodule
